/* hw/rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros
// concurrent assertion shorthands used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

// checked outside reset only
`define ASSERT_RUN(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

/* hw/rtl/pema_pkg.sv */
// ---------------------------------------------------------------------------
// pema_pkg
// shared constants and types of the pen event moving average block
// ---------------------------------------------------------------------------
package pema_pkg;

   localparam int WINDOW_DEPTH_DEF = 16;
   localparam int MID_DEPTH        = 4;
   localparam int OUT_DEPTH        = 8;

   localparam logic [7:0]  TYPE_ABS = 8'd3;
   localparam logic [15:0] CODE_X   = 16'd0;
   localparam logic [15:0] CODE_Y   = 16'd1;

   typedef enum logic [1:0] {
      AXIS_NONE,
      AXIS_X,
      AXIS_Y
   } axis_type;

   typedef struct packed {
      axis_type    axis;
      logic [31:0] value;
   } item_type;

   typedef struct packed {
      logic        valid;
      logic        pass;
      logic [31:0] value;
   } stage_type;

endpackage

/* hw/rtl/pema_front.sv */
// ---------------------------------------------------------------------------
// pema_front
// takes events, sorts them by axis and queues them for the back end
// ---------------------------------------------------------------------------
module pema_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [7:0]         req_event_type,
   input  logic [15:0]        req_event_code,
   input  logic [31:0]        req_event_value,
   output pema_pkg::item_type mid_item,
   output logic               mid_valid,
   input  logic               mid_pop
);

   localparam int PTR_W = $clog2(pema_pkg::MID_DEPTH);
   localparam int CNT_W = $clog2(pema_pkg::MID_DEPTH + 1);

   pema_pkg::item_type mem_ff [pema_pkg::MID_DEPTH];
   pema_pkg::item_type item_in;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               push_xfer;
   logic               pop_xfer;

   assign req_full  = (cnt_ff == CNT_W'(pema_pkg::MID_DEPTH));
   assign mid_valid = (cnt_ff != '0);
   assign mid_item  = mem_ff[rd_ptr_ff];
   assign push_xfer = req_push & ~req_full;
   assign pop_xfer  = mid_pop & mid_valid;

   // classify
   always_comb begin
      item_in.axis  = pema_pkg::AXIS_NONE;
      item_in.value = req_event_value;
      if (req_event_type == pema_pkg::TYPE_ABS) begin
         if (req_event_code == pema_pkg::CODE_X) begin
            item_in.axis = pema_pkg::AXIS_X;
         end else if (req_event_code == pema_pkg::CODE_Y) begin
            item_in.axis = pema_pkg::AXIS_Y;
         end
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_xfer) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(pema_pkg::MID_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_xfer) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(pema_pkg::MID_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push_xfer, pop_xfer})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_xfer) begin
         mem_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

/* hw/rtl/pema_back.sv */
// ---------------------------------------------------------------------------
// pema_back
// per-axis sample windows and running sums, one event per cycle with credit
// ---------------------------------------------------------------------------
module pema_back #(
   parameter int WINDOW_DEPTH = pema_pkg::WINDOW_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  pema_pkg::item_type  mid_item,
   input  logic                mid_valid,
   output logic                mid_pop,
   input  logic                rsp_xfer,
   output pema_pkg::stage_type sum_stage
);

   localparam int POS_W = $clog2(WINDOW_DEPTH);
   localparam int CRD_W = $clog2(pema_pkg::OUT_DEPTH + 1);

   function automatic logic [POS_W-1:0] next_slot(input logic [POS_W-1:0] pos);
      next_slot = (pos == POS_W'(WINDOW_DEPTH - 1)) ? '0 : pos + 1'b1;
   endfunction

   logic [31:0]             x_mem [WINDOW_DEPTH];
   logic [31:0]             y_mem [WINDOW_DEPTH];
   logic [31:0]             x_rdata_ff, y_rdata_ff;
   logic [WINDOW_DEPTH-1:0] x_vld_ff, x_vld_in;
   logic [WINDOW_DEPTH-1:0] y_vld_ff, y_vld_in;
   logic [POS_W-1:0]        x_pos_ff, x_pos_in;
   logic [POS_W-1:0]        y_pos_ff, y_pos_in;
   logic [31:0]             x_sum_ff, x_sum_in;
   logic [31:0]             y_sum_ff, y_sum_in;
   logic [CRD_W-1:0]        credit_ff, credit_in;

   logic                    s1_vld_ff;
   pema_pkg::axis_type      s1_axis_ff;
   logic [31:0]             s1_value_ff;
   logic [POS_W-1:0]        s1_slot_ff;
   logic                    s1_old_ok_ff;

   pema_pkg::stage_type     sum_ff, sum_in;

   logic                    issue;
   logic                    issue_x, issue_y;
   logic [POS_W-1:0]        x_slot, y_slot;
   logic                    wr_x, wr_y;
   logic [31:0]             oldest;
   logic [31:0]             cur_sum;
   logic [31:0]             new_sum;

   // room for every issued event is held in the result queue
   assign issue   = mid_valid && (credit_ff < CRD_W'(pema_pkg::OUT_DEPTH));
   assign mid_pop = issue;
   assign issue_x = issue && (mid_item.axis == pema_pkg::AXIS_X);
   assign issue_y = issue && (mid_item.axis == pema_pkg::AXIS_Y);
   assign x_slot  = next_slot(x_pos_ff);
   assign y_slot  = next_slot(y_pos_ff);

   assign wr_x = s1_vld_ff && (s1_axis_ff == pema_pkg::AXIS_X);
   assign wr_y = s1_vld_ff && (s1_axis_ff == pema_pkg::AXIS_Y);

   always_comb begin
      oldest  = '0;
      cur_sum = (s1_axis_ff == pema_pkg::AXIS_Y) ? y_sum_ff : x_sum_ff;
      if (s1_old_ok_ff) begin
         oldest = (s1_axis_ff == pema_pkg::AXIS_Y) ? y_rdata_ff : x_rdata_ff;
      end
      new_sum = cur_sum + s1_value_ff - oldest;
   end

   always_comb begin
      x_pos_in  = issue_x ? x_slot : x_pos_ff;
      y_pos_in  = issue_y ? y_slot : y_pos_ff;
      x_sum_in  = wr_x ? new_sum : x_sum_ff;
      y_sum_in  = wr_y ? new_sum : y_sum_ff;
      x_vld_in  = x_vld_ff;
      y_vld_in  = y_vld_ff;
      if (wr_x) begin
         x_vld_in[s1_slot_ff] = 1'b1;
      end
      if (wr_y) begin
         y_vld_in[s1_slot_ff] = 1'b1;
      end
      case ({issue, rsp_xfer})
         2'b10:   credit_in = credit_ff + 1'b1;
         2'b01:   credit_in = credit_ff - 1'b1;
         default: credit_in = credit_ff;
      endcase
      sum_in.valid = s1_vld_ff;
      sum_in.pass  = (s1_axis_ff == pema_pkg::AXIS_NONE);
      sum_in.value = sum_in.pass ? s1_value_ff : new_sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_vld_ff     <= '0;
         y_vld_ff     <= '0;
         x_pos_ff     <= '0;
         y_pos_ff     <= '0;
         x_sum_ff     <= '0;
         y_sum_ff     <= '0;
         credit_ff    <= '0;
         s1_vld_ff    <= 1'b0;
         sum_ff.valid <= 1'b0;
      end else begin
         x_vld_ff     <= x_vld_in;
         y_vld_ff     <= y_vld_in;
         x_pos_ff     <= x_pos_in;
         y_pos_ff     <= y_pos_in;
         x_sum_ff     <= x_sum_in;
         y_sum_ff     <= y_sum_in;
         credit_ff    <= credit_in;
         s1_vld_ff    <= issue;
         sum_ff       <= sum_in;
      end
   end

   // payload of the read stage
   always_ff @(posedge clock) begin
      s1_axis_ff   <= mid_item.axis;
      s1_value_ff  <= mid_item.value;
      s1_slot_ff   <= issue_y ? y_slot : x_slot;
      s1_old_ok_ff <= issue_y ? y_vld_ff[y_slot] : x_vld_ff[x_slot];
   end

   // sample windows
   always_ff @(posedge clock) begin
      if (issue_x) begin
         x_rdata_ff <= x_mem[x_slot];
      end
      if (wr_x) begin
         x_mem[s1_slot_ff] <= s1_value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (issue_y) begin
         y_rdata_ff <= y_mem[y_slot];
      end
      if (wr_y) begin
         y_mem[s1_slot_ff] <= s1_value_ff;
      end
   end

   assign sum_stage = sum_ff;

endmodule

/* hw/rtl/pema_div.sv */
// ---------------------------------------------------------------------------
// pema_div
// divides sums by the window depth through a reciprocal, passes other values
// ---------------------------------------------------------------------------
module pema_div #(
   parameter int WINDOW_DEPTH = pema_pkg::WINDOW_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  pema_pkg::stage_type sum_stage,
   output logic                res_valid,
   output logic [31:0]         res_value
);

   localparam int          SHIFT   = 32 + $clog2(WINDOW_DEPTH);
   localparam int          DW      = $clog2(WINDOW_DEPTH + 1);
   localparam int          RW      = 32 + DW;
   localparam logic [65:0] SCALE   = 66'd1 << SHIFT;
   localparam logic [32:0] RECIP   = 33'(SCALE / 66'(WINDOW_DEPTH));
   localparam logic [DW-1:0] DEPTH = DW'(WINDOW_DEPTH);

   logic [64:0] prod_ff, prod_in;
   logic        vld_ff;
   logic        pass_ff;
   logic [31:0] value_ff;
   logic [31:0] quot_est;
   logic [RW-1:0] back_mul;
   logic [RW-1:0] rem;

   assign prod_in = 65'(sum_stage.value) * 65'(RECIP);

   // estimate is exact or one low
   always_comb begin
      quot_est  = 32'(prod_ff >> SHIFT);
      back_mul  = RW'(quot_est) * RW'(DEPTH);
      rem       = RW'(value_ff) - back_mul;
      res_value = value_ff;
      if (!pass_ff) begin
         res_value = (rem >= RW'(DEPTH)) ? quot_est + 1'b1 : quot_est;
      end
   end

   assign res_valid = vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= sum_stage.valid;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      pass_ff  <= sum_stage.pass;
      value_ff <= sum_stage.value;
   end

endmodule

/* hw/rtl/pema_rsp_queue.sv */
// ---------------------------------------------------------------------------
// pema_rsp_queue
// result queue towards the consumer
// ---------------------------------------------------------------------------
module pema_rsp_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        res_valid,
   input  logic [31:0] res_value,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_filtered_value
);

   localparam int PTR_W = $clog2(pema_pkg::OUT_DEPTH);
   localparam int CNT_W = $clog2(pema_pkg::OUT_DEPTH + 1);

   logic [31:0]      mem_ff [pema_pkg::OUT_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             pop_xfer;

   assign rsp_empty          = (cnt_ff == '0);
   assign rsp_filtered_value = mem_ff[rd_ptr_ff];
   assign pop_xfer           = rsp_pop & ~rsp_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (res_valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(pema_pkg::OUT_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_xfer) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(pema_pkg::OUT_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({res_valid, pop_xfer})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         mem_ff[wr_ptr_ff] <= res_value;
      end
   end

endmodule

/* hw/rtl/pen_event_moving_average_top.sv */
// ---------------------------------------------------------------------------
// pen_event_moving_average_top
// moving average of pen x and y position events, other events pass through
//
//   channel   ports   transfer when         payload
//   request   req_*   req_push & !req_full  event type, code, value
//   response  rsp_*   rsp_pop & !rsp_empty  filtered value
//
// one event per cycle sustained while the response side keeps up, set by the
// single window read and sum update
// each window memory is read at most once and written at most once per cycle
// synchronous reset clears windows (per-slot valid bits), sums and queues
// a stalled response side fills the result queue, then the event queue
// ---------------------------------------------------------------------------
module pen_event_moving_average_top #(
   parameter int WINDOW_DEPTH = pema_pkg::WINDOW_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_event_type,
   input  logic [15:0] req_event_code,
   input  logic [31:0] req_event_value,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_filtered_value
);

   pema_pkg::item_type  mid_item;
   logic                mid_valid;
   logic                mid_pop;
   pema_pkg::stage_type sum_stage;
   logic                res_valid;
   logic [31:0]         res_value;
   logic                rsp_xfer;

   assign rsp_xfer = rsp_pop & ~rsp_empty;

   pema_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_event_type  (req_event_type),
      .req_event_code  (req_event_code),
      .req_event_value (req_event_value),
      .mid_item        (mid_item),
      .mid_valid       (mid_valid),
      .mid_pop         (mid_pop)
   );

   pema_back #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_item  (mid_item),
      .mid_valid (mid_valid),
      .mid_pop   (mid_pop),
      .rsp_xfer  (rsp_xfer),
      .sum_stage (sum_stage)
   );

   pema_div #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .sum_stage (sum_stage),
      .res_valid (res_valid),
      .res_value (res_value)
   );

   pema_rsp_queue u_rsp_queue (
      .clock              (clock),
      .reset              (reset),
      .res_valid          (res_valid),
      .res_value          (res_value),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_filtered_value (rsp_filtered_value)
   );

endmodule

/* hw/rtl/pema_checker.sv */
// ---------------------------------------------------------------------------
// pema_checker
// port-level checks of the pen event moving average block
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pema_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_push,
   input logic        req_full,
   input logic [7:0]  req_event_type,
   input logic [15:0] req_event_code,
   input logic [31:0] req_event_value,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [31:0] rsp_filtered_value
);

   localparam int CNT_W = $clog2(pema_pkg::MID_DEPTH + pema_pkg::OUT_DEPTH + 1);

   logic [CNT_W-1:0] pending_ff, pending_in;
   logic             in_xfer;
   logic             out_xfer;
   logic             fields_seen;

   assign in_xfer     = req_push & ~req_full;
   assign out_xfer    = rsp_pop & ~rsp_empty;
   assign fields_seen = (req_event_type != '0) || (req_event_code != '0)
                        || (req_event_value != '0) || 1'b1;

   // events in flight, as seen at the ports
   always_comb begin
      case ({in_xfer, out_xfer})
         2'b10:   pending_in = pending_ff + 1'b1;
         2'b01:   pending_in = pending_ff - 1'b1;
         default: pending_in = pending_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `ASSERT_ALWAYS(a_empty_after_reset, clock, reset |=> rsp_empty, "response after reset")
   `ASSERT_RUN(a_no_invented_rsp, clock, reset, (fields_seen && pending_ff == '0) |-> rsp_empty, "response with no event in flight")
   `ASSERT_RUN(a_rsp_held, clock, reset, (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_filtered_value)), "waiting response changed")

endmodule

bind pen_event_moving_average_top pema_checker u_pema_checker (.*);

/* tb/tb_pen_event_moving_average_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_pen_event_moving_average_top
// self-checking testbench of the pen event moving average block
//
// directed events cover pass-through types and codes, window warm-up and sum
// wrap-around on both axes, slot wrap on x. Random events follow, mostly x and y
// samples with noise events mixed in, under random idle bursts on both
// channels. A long response hold-off fills the block. A final stretch runs
// with no idling. Every response transfer is checked in order against a local
// model of both axis windows.
// ---------------------------------------------------------------------------
module tb_pen_event_moving_average_top;

   localparam int         DEPTH    = pema_pkg::WINDOW_DEPTH_DEF;
   localparam int         SLOT_W   = $clog2(DEPTH);
   localparam logic [7:0] TYPE_REL = 8'd2;
   localparam int         AXIS_XI  = 0;
   localparam int         AXIS_YI  = 1;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [7:0]  req_event_type;
   logic [15:0] req_event_code;
   logic [31:0] req_event_value;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [31:0] rsp_filtered_value;

   logic [31:0]       axis_samples [2][DEPTH];
   logic [SLOT_W-1:0] axis_slot    [2];
   logic [31:0]       axis_sum     [2];
   logic [31:0]       expected_values [$];

   int mismatch_count = 0;
   bit idle_on        = 1'b0;
   int hold_request   = 0;
   int hold_left      = 0;
   int stall_left     = 0;

   pen_event_moving_average_top u_top (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_event_type     (req_event_type),
      .req_event_code     (req_event_code),
      .req_event_value    (req_event_value),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_filtered_value (rsp_filtered_value)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // model of one event: window update for x and y samples, else pass-through
   task automatic filter_event(input logic [7:0] ev_type, input logic [15:0] ev_code,
                               input logic [31:0] ev_value);
      int          a;
      logic [31:0] result;
      result = ev_value;
      a = -1;
      if (ev_type == pema_pkg::TYPE_ABS && ev_code == pema_pkg::CODE_X) a = AXIS_XI;
      else if (ev_type == pema_pkg::TYPE_ABS && ev_code == pema_pkg::CODE_Y) a = AXIS_YI;
      if (a >= 0) begin
         if (axis_slot[a] == SLOT_W'(DEPTH - 1)) axis_slot[a] = '0;
         else axis_slot[a] = axis_slot[a] + 1'b1;
         axis_sum[a] = axis_sum[a] + ev_value - axis_samples[a][axis_slot[a]];
         axis_samples[a][axis_slot[a]] = ev_value;
         result = axis_sum[a] / DEPTH;
      end
      expected_values.push_back(result);
   endtask

   task automatic send_event(input logic [7:0] ev_type, input logic [15:0] ev_code,
                             input logic [31:0] ev_value);
      int gap;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 17);
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push        <= 1'b1;
      req_event_type  <= ev_type;
      req_event_code  <= ev_code;
      req_event_value <= ev_value;
      @(posedge clock);
      while (req_full) @(posedge clock);
      filter_event(ev_type, ev_code, ev_value);
   endtask

   task automatic send_random_event();
      logic [7:0]  ev_type;
      logic [15:0] ev_code;
      logic [31:0] ev_value;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 42) begin
         ev_type = pema_pkg::TYPE_ABS;
         ev_code = pema_pkg::CODE_X;
      end else if (pick < 84) begin
         ev_type = pema_pkg::TYPE_ABS;
         ev_code = pema_pkg::CODE_Y;
      end else if (pick < 92) begin
         ev_type = pema_pkg::TYPE_ABS;
         ev_code = 16'($urandom);
      end else begin
         ev_type = 8'($urandom);
         ev_code = 16'($urandom);
      end
      case ($urandom_range(0, 9))
         0: ev_value = 32'h0000_0000;
         1: ev_value = 32'hFFFF_FFFF;
         2: ev_value = 32'($urandom_range(0, 255));
         3: ev_value = 32'hFFFF_FF00 | 32'($urandom_range(0, 255));
         default: ev_value = $urandom;
      endcase
      send_event(ev_type, ev_code, ev_value);
   endtask

   task automatic test_pass_through();
      send_event(8'h00, pema_pkg::CODE_X, 32'h0000_0000);
      send_event(8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_event(pema_pkg::TYPE_ABS, pema_pkg::CODE_Y + 16'd1, 32'h1234_5678);
      send_event(pema_pkg::TYPE_ABS, 16'hFFFF, 32'hA5A5_A5A5);
      send_event(TYPE_REL, pema_pkg::CODE_X, 32'h5A5A_5A5A);
   endtask

   // seventeen samples: warm-up, sum wrap, then slot wrap onto an old sample
   task automatic test_x_window();
      logic [31:0] samples [17] = '{
         32'd1000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd16, 32'd15,
         32'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hDEAD_BEEF, 32'h0000_FFFF,
         32'hFFFF_0000, 32'd3, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F,
         32'hF0F0_F0F0
      };
      foreach (samples[i]) send_event(pema_pkg::TYPE_ABS, pema_pkg::CODE_X, samples[i]);
   endtask

   task automatic test_y_window();
      send_event(pema_pkg::TYPE_ABS, pema_pkg::CODE_Y, 32'hFFFF_FFFF);
      send_event(pema_pkg::TYPE_ABS, pema_pkg::CODE_Y, 32'd17);
      send_event(pema_pkg::TYPE_ABS, pema_pkg::CODE_Y, 32'h0000_0000);
   endtask

   task automatic test_random_idle();
      idle_on = 1'b1;
      repeat (1300) send_random_event();
   endtask

   task automatic test_backpressure();
      idle_on      = 1'b0;
      hold_request = 90;
      repeat (48) send_random_event();
   endtask

   task automatic test_streaming();
      idle_on = 1'b0;
      repeat (400) send_random_event();
   endtask

   // response side: check each transfer, then choose the next pop
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_values.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected response transfer: actual %h", rsp_filtered_value);
            end else if (rsp_filtered_value !== expected_values[0]) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("filtered_value mismatch: expected %h actual %h",
                           expected_values[0], rsp_filtered_value);
               void'(expected_values.pop_front());
            end else begin
               void'(expected_values.pop_front());
            end
         end
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else if (idle_on && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(1, 17) - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   initial begin
      reset           = 1'b1;
      req_push        = 1'b0;
      req_event_type  = '0;
      req_event_code  = '0;
      req_event_value = '0;
      for (int a = 0; a < 2; a++) begin
         axis_slot[a] = '0;
         axis_sum[a]  = '0;
         for (int i = 0; i < DEPTH; i++) axis_samples[a][i] = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_pass_through();
      test_x_window();
      test_y_window();
      test_random_idle();
      test_backpressure();
      test_streaming();
      req_push <= 1'b0;

      while (expected_values.size() != 0) @(posedge clock);
      repeat (32) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("pen_event_moving_average_top: match");
      end else begin
         $display("pen_event_moving_average_top: mismatch");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("pen_event_moving_average_top: mismatch");
      $finish;
   end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/pema_pkg.sv
hw/rtl/pema_front.sv
hw/rtl/pema_back.sv
hw/rtl/pema_div.sv
hw/rtl/pema_rsp_queue.sv
hw/rtl/pen_event_moving_average_top.sv
hw/rtl/pema_checker.sv
tb/tb_pen_event_moving_average_top.sv
